/* rtl/demc_pkg.sv */
// Shared types, register codes and fixed-point constants of the difference-equation controller.
`timescale 1ns / 1ps

package demc_pkg;

	// Number of coefficient pairs and depth of the kept histories.
	localparam int COEF_COUNT = 3;
	localparam int HIST_ORDER = 3;

	localparam int SAMPLE_W = 24;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int COEF_W   = 32;
	localparam int CTL_W    = 32;
	localparam int DRIVE_W  = 9;
	localparam int ORDER_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_SHIFT = 16;

	// Product widths and the accumulator that holds the exact sum of all products.
	localparam int PE_W  = COEF_W + ERR_W;
	localparam int PO_W  = COEF_W + CTL_W;
	localparam int ACC_W = PO_W + 3;
	localparam int SHR_W = ACC_W - FRAC_SHIFT;

	// Drive limit in Q.8: 255.0 and -255.0.
	localparam logic signed [CTL_W-1:0] DRIVE_MAX_Q8 = 32'sd65280;
	localparam logic signed [CTL_W-1:0] DRIVE_MIN_Q8 = -32'sd65280;
	localparam logic signed [CTL_W-1:0] CTL_MAX = 32'sh7fff_ffff;
	localparam logic signed [CTL_W-1:0] CTL_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_MODE    = 3'd0,
		REG_FILTER_ORDER = 3'd1,
		REG_ERR_COEF_0   = 3'd2,
		REG_ERR_COEF_1   = 3'd3,
		REG_ERR_COEF_2   = 3'd4,
		REG_OUT_COEF_0   = 3'd5,
		REG_OUT_COEF_1   = 3'd6,
		REG_OUT_COEF_2   = 3'd7
	} reg_idx_t;

	localparam logic LOOP_SPEED    = 1'b0;
	localparam logic LOOP_POSITION = 1'b1;
	localparam logic ITEM_SAMPLE   = 1'b0;
	localparam logic ITEM_CLEAR    = 1'b1;

	typedef struct packed {
		logic                                loop_mode;
		logic [ORDER_W-1:0]                  filter_order;
		logic [COEF_COUNT-1:0][COEF_W-1:0]   err_coef;
		logic [COEF_COUNT-1:0][COEF_W-1:0]   out_coef;
	} cfg_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [CTL_W-1:0]   control_value;
		logic                      clamped;
	} result_t;

endpackage

/* rtl/demc_cfg.sv */
// Configuration register file of the difference-equation controller.
`timescale 1ns / 1ps

module demc_cfg import demc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LOOP_MODE:    cfg_q.loop_mode       <= cfg_data[0];
				REG_FILTER_ORDER: cfg_q.filter_order    <= cfg_data[ORDER_W-1:0];
				REG_ERR_COEF_0:   cfg_q.err_coef[0]     <= cfg_data[COEF_W-1:0];
				REG_ERR_COEF_1:   cfg_q.err_coef[1]     <= cfg_data[COEF_W-1:0];
				REG_ERR_COEF_2:   cfg_q.err_coef[2]     <= cfg_data[COEF_W-1:0];
				REG_OUT_COEF_0:   cfg_q.out_coef[0]     <= cfg_data[COEF_W-1:0];
				REG_OUT_COEF_1:   cfg_q.out_coef[1]     <= cfg_data[COEF_W-1:0];
				REG_OUT_COEF_2:   cfg_q.out_coef[2]     <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/demc_core.sv */
// Error and control histories with the sum of products, saturation and drive clamp.
`timescale 1ns / 1ps

module demc_core import demc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       adv,
	input  logic                       mode,
	input  logic signed [SAMPLE_W-1:0] reference,
	input  logic signed [SAMPLE_W-1:0] measurement,
	output result_t                    res
);

	// err_hist_q[i] holds e[k-1-i]; ctl_hist_q[i] holds u[k-1-i], clamped in speed mode.
	logic signed [ERR_W-1:0] err_hist_q [COEF_COUNT-1];
	logic signed [CTL_W-1:0] ctl_hist_q [COEF_COUNT];

	logic signed [ERR_W-1:0] e_now;
	logic signed [ERR_W-1:0] e_vec [COEF_COUNT];
	logic signed [PE_W-1:0]  pe [COEF_COUNT];
	logic signed [PO_W-1:0]  po [COEF_COUNT];
	logic [COEF_COUNT-1:0]   term_on;
	logic signed [ACC_W-1:0] acc;
	logic signed [SHR_W-1:0] shifted;
	logic signed [CTL_W-1:0] u;
	logic signed [CTL_W-1:0] sat;
	logic signed [CTL_W-1:0] hist_val;
	logic signed [16:0]      sat17;
	logic signed [16:0]      rnd17;
	logic                    clamp_hit;

	assign e_now = ERR_W'(reference) - ERR_W'(measurement);

	always_comb begin
		e_vec[0] = e_now;
		for (int i = 1; i < COEF_COUNT; i++) begin
			e_vec[i] = err_hist_q[i-1];
		end
	end

	// Independent products; a term counts only below the programmed order.
	always_comb begin
		acc = '0;
		for (int i = 0; i < COEF_COUNT; i++) begin
			term_on[i] = (cfg.filter_order > ORDER_W'(i)) && (i < HIST_ORDER);
			pe[i] = $signed(cfg.err_coef[i]) * e_vec[i];
			po[i] = $signed(cfg.out_coef[i]) * ctl_hist_q[i];
			if (term_on[i]) begin
				acc = acc + ACC_W'(pe[i]) + ACC_W'(po[i]);
			end
		end
	end

	// Floor shift by the coefficient fraction, then saturate to 32 bits.
	assign shifted = acc[ACC_W-1:FRAC_SHIFT];

	always_comb begin
		if (shifted[SHR_W-1:CTL_W-1] == '0 || shifted[SHR_W-1:CTL_W-1] == '1) begin
			u = shifted[CTL_W-1:0];
		end else if (shifted[SHR_W-1]) begin
			u = CTL_MIN;
		end else begin
			u = CTL_MAX;
		end
	end

	always_comb begin
		clamp_hit = 1'b0;
		sat       = u;
		if (cfg.loop_mode == LOOP_SPEED) begin
			if (u < 0) begin
				sat       = '0;
				clamp_hit = 1'b1;
			end else if (u > DRIVE_MAX_Q8) begin
				sat       = DRIVE_MAX_Q8;
				clamp_hit = 1'b1;
			end
			hist_val = sat;
		end else begin
			if (u < DRIVE_MIN_Q8) begin
				sat       = DRIVE_MIN_Q8;
				clamp_hit = 1'b1;
			end else if (u > DRIVE_MAX_Q8) begin
				sat       = DRIVE_MAX_Q8;
				clamp_hit = 1'b1;
			end
			hist_val = u;
		end
	end

	// Truncation toward zero: a negative value is biased by 255 before the shift.
	assign sat17 = sat[16:0];
	assign rnd17 = sat17[16] ? (sat17 + 17'sd255) : sat17;

	always_comb begin
		if (mode == ITEM_CLEAR) begin
			res = '0;
		end else begin
			res.drive         = rnd17[16:8];
			res.control_value = u;
			res.clamped       = clamp_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_COUNT - 1; i++) begin
				err_hist_q[i] <= '0;
			end
			for (int i = 0; i < COEF_COUNT; i++) begin
				ctl_hist_q[i] <= '0;
			end
		end else if (adv) begin
			if (mode == ITEM_CLEAR) begin
				for (int i = 0; i < COEF_COUNT - 1; i++) begin
					err_hist_q[i] <= '0;
				end
				for (int i = 0; i < COEF_COUNT; i++) begin
					ctl_hist_q[i] <= '0;
				end
			end else begin
				err_hist_q[0] <= e_now;
				for (int i = 1; i < COEF_COUNT - 1; i++) begin
					err_hist_q[i] <= err_hist_q[i-1];
				end
				ctl_hist_q[0] <= hist_val;
				for (int i = 1; i < COEF_COUNT; i++) begin
					ctl_hist_q[i] <= ctl_hist_q[i-1];
				end
			end
		end
	end

endmodule

/* rtl/difference_equation_motor_controller.sv */
// Top level of the difference-equation motor controller: input and result registers.
`timescale 1ns / 1ps
//
// Channel   Direction  Payload
// s_axis    in         tdata: reference[23:0], measurement[47:24]; tuser: mode
// m_axis    out        tdata: drive[8:0], control_value[40:9], zero[47:41]; tuser: clamped
// cfg       in         cfg_we, cfg_index (register number), cfg_data (value)
//
// An input transaction lands in the input register; the controller equation is then
// evaluated and the result register is loaded when the stage advances. A new sample
// is accepted every cycle while m_axis does not stall; the recurrence u[k-1] -> u[k]
// closes in the single combinational pass between the input and result registers.
// Reset (arst_n low) clears valid flags, configuration and both histories to zero.
// When m_axis stalls, the result register holds and one more sample waits in the
// input register before s_axis_tready drops.

module difference_equation_motor_controller import demc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Sample stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [47:0]           s_axis_tdata,  // reference[23:0], measurement[47:24]
	input  logic                  s_axis_tuser,  // mode (clear when set)
	// Result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [47:0]           m_axis_tdata,  // drive[8:0], control_value[40:9],
	                                             // zero fill[47:41]
	output logic                  m_axis_tuser   // clamped
);

	cfg_t    cfg;
	result_t res;

	// Input register stage.
	logic                       in_valid_s1;
	logic                       mode_s1;
	logic signed [SAMPLE_W-1:0] reference_s1;
	logic signed [SAMPLE_W-1:0] measurement_s1;

	// Result register.
	logic    out_valid_q;
	result_t out_res_q;

	logic adv;

	// The stage advances when it holds a sample and the result register is empty or being drained.
	assign adv           = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || adv;

	demc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	demc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.adv         (adv),
		.mode        (mode_s1),
		.reference   (reference_s1),
		.measurement (measurement_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// Payload needs no reset; it is only looked at while its valid flag is set.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1        <= s_axis_tuser;
			reference_s1   <= s_axis_tdata[SAMPLE_W-1:0];
			measurement_s1 <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_res_q.control_value, out_res_q.drive};
	assign m_axis_tuser  = out_res_q.clamped;

endmodule

/* rtl/demc_checker.sv */
// Port-level checks of the difference-equation controller and their binding.
`timescale 1ns / 1ps

module demc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// An empty result register always lets the input side move.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while result register empty");

	// A stalled result keeps its valid flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn under stall");

	// A clamped result sits at a drive limit or at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			(m_axis_tdata[8:0] == 9'd255 || m_axis_tdata[8:0] == 9'h101 ||
			 m_axis_tdata[8:0] == 9'd0))
		else $error("clamped flag without a limited drive");

	// The drive never leaves -255..255 and the fill bits stay zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[8:0] != 9'h100 && m_axis_tdata[47:41] == 7'd0))
		else $error("drive out of range or fill bits set");

endmodule

bind difference_equation_motor_controller demc_checker u_demc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
